FILE: design/arpl_pkg.sv
// ============================================================================
// arpl_pkg - shared types and constants of the adaptive replacement policy
// Request, result and configuration layouts, mode and register codes.
// ============================================================================
package arpl_pkg;

    // Field widths
    localparam int SET_W     = 11;
    localparam int WAY_IN_W  = 4;
    localparam int CNT_W     = 7;
    localparam int BIP_W     = 5;
    localparam int MODE_W    = 2;
    localparam int RRIP_W    = 2;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    // Request kinds
    localparam logic REQ_FIND   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // Set modes
    localparam logic [MODE_W-1:0] MODE_SRRIP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LRU   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BIP   = 2'd2;

    // Re-reference prediction values: distant, long and near
    localparam logic [RRIP_W-1:0] RRPV_DISTANT = 2'd3;
    localparam logic [RRIP_W-1:0] RRPV_LONG    = 2'd1;
    localparam logic [RRIP_W-1:0] RRPV_NEAR    = 2'd0;

    // Window counter saturation
    localparam logic [CNT_W-1:0] CNT_SAT = 7'd127;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIP_PERIOD     = 2'd3;

    // Configuration reset values
    localparam logic [CNT_W-1:0] WINDOW_LENGTH_RST  = 7'd64;
    localparam logic [CNT_W-1:0] HIT_THRESHOLD_RST  = 7'd45;
    localparam logic [CNT_W-1:0] MISS_THRESHOLD_RST = 7'd51;
    localparam logic [BIP_W-1:0] BIP_PERIOD_RST     = 5'd20;

    typedef struct packed {
        logic                req_type;
        logic [SET_W-1:0]    set_index;
        logic [WAY_IN_W-1:0] way_index;
        logic                was_hit;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0] window_length;
        logic [CNT_W-1:0] hit_threshold;
        logic [CNT_W-1:0] miss_threshold;
        logic [BIP_W-1:0] bip_period;
    } cfg_t;

    typedef struct packed {
        logic [WAY_IN_W-1:0] victim_way;
        logic [MODE_W-1:0]   set_mode;
    } res_t;

endpackage

FILE: design/arpl_update.sv
// ============================================================================
// arpl_update - set row read-modify logic
// Takes one set row as read from memory and a request, and returns the
// victim, the mode, the row to write back and the next shared BIP count.
// Row layout from bit 0: RRIP values, LRU ages, window hits, window misses,
// mode.
// ============================================================================
module arpl_update #(
    parameter int WAYS = 16,
    localparam int LW       = $clog2(WAYS),
    localparam int AGE_LO   = arpl_pkg::RRIP_W * WAYS,
    localparam int HIT_LO   = AGE_LO + LW * WAYS,
    localparam int MISS_LO  = HIT_LO + arpl_pkg::CNT_W,
    localparam int MODE_LO  = MISS_LO + arpl_pkg::CNT_W,
    localparam int ROW_W    = MODE_LO + arpl_pkg::MODE_W
) (
    input  logic [ROW_W-1:0]            row_i,
    input  arpl_pkg::req_t              req_i,
    input  arpl_pkg::cfg_t              cfg_i,
    input  logic [arpl_pkg::BIP_W-1:0]  bip_cnt_i,
    output logic [ROW_W-1:0]            row_o,
    output logic [arpl_pkg::BIP_W-1:0]  bip_cnt_o,
    output arpl_pkg::res_t              res_o
);

    logic [arpl_pkg::RRIP_W-1:0] rr     [WAYS];
    logic [arpl_pkg::RRIP_W-1:0] rr_new [WAYS];
    logic [LW-1:0]               age     [WAYS];
    logic [LW-1:0]               age_new [WAYS];
    logic [arpl_pkg::CNT_W-1:0]  hits, misses, hits_n, misses_n;
    logic [arpl_pkg::MODE_W-1:0] mode, mode_n;
    logic                        any3, any2, any1;
    logic [arpl_pkg::RRIP_W-1:0] rr_max, rr_add;
    logic [LW-1:0]               rr_vic, lru_vic, way_sel, victim;
    logic [LW-1:0]               old_age;
    logic [arpl_pkg::CNT_W:0]    win_sum;
    logic                        way_ok;
    logic [arpl_pkg::BIP_W-1:0]  bip_inc;
    logic [31:0]                 vic_ext;

    always_comb begin
        // Unpack the row
        for (int w = 0; w < WAYS; w++) begin
            rr[w]  = row_i[arpl_pkg::RRIP_W*w +: arpl_pkg::RRIP_W];
            age[w] = row_i[AGE_LO + LW*w +: LW];
        end
        hits   = row_i[HIT_LO +: arpl_pkg::CNT_W];
        misses = row_i[MISS_LO +: arpl_pkg::CNT_W];
        mode   = row_i[MODE_LO +: arpl_pkg::MODE_W];

        // RRIP maximum and the aging step that lifts it to the distant value
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            any3 = any3 | (rr[w] == 2'd3);
            any2 = any2 | (rr[w] == 2'd2);
            any1 = any1 | (rr[w] == 2'd1);
        end
        rr_max = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
        rr_add = arpl_pkg::RRPV_DISTANT - rr_max;

        // Lowest way holding the maximum becomes distant after aging
        rr_vic = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (rr[w] == rr_max) begin
                rr_vic = LW'(w);
            end
        end

        // LRU ages form a permutation: the oldest way holds the top age
        lru_vic = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (age[w] == LW'(WAYS - 1)) begin
                lru_vic = LW'(w);
            end
        end

        // Defaults: row unchanged
        for (int w = 0; w < WAYS; w++) begin
            rr_new[w]  = rr[w];
            age_new[w] = age[w];
        end
        hits_n    = hits;
        misses_n  = misses;
        mode_n    = mode;
        bip_cnt_o = bip_cnt_i;
        victim    = '0;
        way_ok    = int'(req_i.way_index) < WAYS;
        way_sel   = LW'(req_i.way_index);
        old_age   = age[way_sel];
        bip_inc   = bip_cnt_i + 1'b1;
        win_sum   = '0;

        if (req_i.req_type == arpl_pkg::REQ_FIND) begin
            // Victim search, aging RRIP values outside LRU mode
            if (mode == arpl_pkg::MODE_LRU) begin
                victim = lru_vic;
            end else begin
                victim = rr_vic;
                for (int w = 0; w < WAYS; w++) begin
                    rr_new[w] = rr[w] + rr_add;
                end
            end
        end else begin
            // Count the access in the window, saturating
            if (req_i.was_hit) begin
                if (hits < arpl_pkg::CNT_SAT) begin
                    hits_n = hits + 1'b1;
                end
            end else begin
                if (misses < arpl_pkg::CNT_SAT) begin
                    misses_n = misses + 1'b1;
                end
            end

            // Close the window and pick the mode
            win_sum = {1'b0, hits_n} + {1'b0, misses_n};
            if (win_sum >= {1'b0, cfg_i.window_length}) begin
                if (hits_n > cfg_i.hit_threshold) begin
                    mode_n = arpl_pkg::MODE_LRU;
                end else if (misses_n > cfg_i.miss_threshold) begin
                    mode_n = arpl_pkg::MODE_BIP;
                end else begin
                    mode_n = arpl_pkg::MODE_SRRIP;
                end
                hits_n   = '0;
                misses_n = '0;
            end

            // Promote or insert the accessed way under the new mode
            if (way_ok) begin
                if (mode_n == arpl_pkg::MODE_LRU) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (age[w] < old_age) begin
                            age_new[w] = age[w] + 1'b1;
                        end
                    end
                    age_new[way_sel] = '0;
                end else if (mode_n == arpl_pkg::MODE_BIP) begin
                    if (req_i.was_hit) begin
                        rr_new[way_sel] = arpl_pkg::RRPV_NEAR;
                    end else if (bip_inc >= cfg_i.bip_period) begin
                        rr_new[way_sel] = arpl_pkg::RRPV_NEAR;
                        bip_cnt_o       = '0;
                    end else begin
                        rr_new[way_sel] = arpl_pkg::RRPV_DISTANT;
                        bip_cnt_o       = bip_inc;
                    end
                end else begin
                    rr_new[way_sel] = req_i.was_hit ? arpl_pkg::RRPV_NEAR
                                                    : arpl_pkg::RRPV_LONG;
                end
            end
        end

        // Pack the row back
        for (int w = 0; w < WAYS; w++) begin
            row_o[arpl_pkg::RRIP_W*w +: arpl_pkg::RRIP_W] = rr_new[w];
            row_o[AGE_LO + LW*w +: LW]                    = age_new[w];
        end
        row_o[HIT_LO +: arpl_pkg::CNT_W]   = hits_n;
        row_o[MISS_LO +: arpl_pkg::CNT_W]  = misses_n;
        row_o[MODE_LO +: arpl_pkg::MODE_W] = mode_n;

        // Result: victim kept to the port width
        vic_ext          = 32'(victim);
        res_o.victim_way = vic_ext[arpl_pkg::WAY_IN_W-1:0];
        res_o.set_mode   = mode_n;
    end

endmodule

FILE: design/adaptive_srrip_lru_bip_replacement_top.sv
// ============================================================================
// adaptive_srrip_lru_bip_replacement_top - adaptive SRRIP/LRU/BIP replacement
// Per-set replacement state in one row memory; each request reads its set
// row, modifies it and writes it back.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  s_      | in        | s_tvalid/s_tready  | tuser: req_type; tdata: set,way,hit
//  m_      | out       | m_tvalid/m_tready  | tdata: victim_way, set_mode
//  cfg_    | in        | cfg_wr_en          | cfg_wr_index, cfg_wr_data
//
//  Each request is read, then modified: accepting it reads the set row from the
//  single-port row memory into a register, and the modify state then writes
//  the modified row back and loads the result register.
//  After reset a clearing pass writes the reset row to every set (2048 sets
//  by default); s_tready stays low meanwhile.
//  A result waiting in the output register does not block a new request; the
//  following request holds in its modify cycle until that result is taken.
// ============================================================================
module adaptive_srrip_lru_bip_replacement_top #(
    parameter int SETS = 2048,
    parameter int WAYS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] set_index, [14:11] way_index, [15] was_hit
    input  logic [0:0]  s_tuser,   // [0] req_type
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] victim_way, [5:4] set_mode, [7:6] zero
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [arpl_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [arpl_pkg::CFG_W-1:0]         cfg_wr_data
);

    localparam int SW      = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int LW      = $clog2(WAYS);
    localparam int AGE_LO  = arpl_pkg::RRIP_W * WAYS;
    localparam int HIT_LO  = AGE_LO + LW * WAYS;
    localparam int ROW_W   = HIT_LO + 2 * arpl_pkg::CNT_W + arpl_pkg::MODE_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    logic                          state_reg, state_next;
    logic                          clearing_reg;
    logic [SW-1:0]                 clr_cnt_reg;
    arpl_pkg::req_t                req_reg, in_req;
    logic                          in_range_reg, in_range;
    arpl_pkg::cfg_t                cfg_reg;
    logic [arpl_pkg::BIP_W-1:0]    bip_cnt_reg, bip_cnt_next;
    logic                          m_tvalid_reg;
    arpl_pkg::res_t                res_reg, calc_res;
    logic [ROW_W-1:0]              mem [SETS];
    logic [ROW_W-1:0]              rd_data_reg;
    logic [ROW_W-1:0]              row_new, rst_row, mem_wdata;
    logic [SW-1:0]                 rd_addr, mem_waddr;
    logic                          mem_we;
    logic                          accept, calc_done;

    // Unpack the request
    always_comb begin
        in_req.req_type  = s_tuser[0];
        in_req.set_index = s_tdata[10:0];
        in_req.way_index = s_tdata[14:11];
        in_req.was_hit   = s_tdata[15];
    end

    assign in_range  = int'(in_req.set_index) < SETS;
    assign rd_addr   = SW'(in_req.set_index);
    assign s_tready  = !clearing_reg && (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign calc_done = (state_reg == ST_CALC) && (!m_tvalid_reg || m_tready);

    // Reset row: distant RRIP, ages equal to way numbers, empty window, SRRIP
    always_comb begin
        rst_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            rst_row[arpl_pkg::RRIP_W*w +: arpl_pkg::RRIP_W] = arpl_pkg::RRPV_DISTANT;
            rst_row[AGE_LO + LW*w +: LW]                    = LW'(w);
        end
    end

    // Row modify logic
    arpl_update #(
        .WAYS(WAYS)
    ) u_update (
        .row_i     (rd_data_reg),
        .req_i     (req_reg),
        .cfg_i     (cfg_reg),
        .bip_cnt_i (bip_cnt_reg),
        .row_o     (row_new),
        .bip_cnt_o (bip_cnt_next),
        .res_o     (calc_res)
    );

    // Memory write: clearing pass or write back of the modified row
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = SW'(req_reg.set_index);
        mem_wdata = row_new;
        if (clearing_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = rst_row;
        end else if (calc_done && in_range_reg) begin
            mem_we = 1'b1;
        end
    end

    // Row memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (calc_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            bip_cnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            // Advance the clearing pass
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SW'(SETS - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            // Hold the result until it is taken
            if (calc_done) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (calc_done && in_range_reg) begin
                bip_cnt_reg <= bip_cnt_next;
            end
        end
    end

    // Capture the request and the result
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg      <= in_req;
            in_range_reg <= in_range;
        end
        if (calc_done) begin
            if (in_range_reg) begin
                res_reg <= calc_res;
            end else begin
                res_reg <= '0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_length  <= arpl_pkg::WINDOW_LENGTH_RST;
            cfg_reg.hit_threshold  <= arpl_pkg::HIT_THRESHOLD_RST;
            cfg_reg.miss_threshold <= arpl_pkg::MISS_THRESHOLD_RST;
            cfg_reg.bip_period     <= arpl_pkg::BIP_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                arpl_pkg::CFG_WINDOW_LENGTH:  cfg_reg.window_length  <= cfg_wr_data;
                arpl_pkg::CFG_HIT_THRESHOLD:  cfg_reg.hit_threshold  <= cfg_wr_data;
                arpl_pkg::CFG_MISS_THRESHOLD: cfg_reg.miss_threshold <= cfg_wr_data;
                arpl_pkg::CFG_BIP_PERIOD: begin
                    cfg_reg.bip_period <= cfg_wr_data[arpl_pkg::BIP_W-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, res_reg.set_mode, res_reg.victim_way};

endmodule

FILE: sim/tb_adaptive_srrip_lru_bip_replacement_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_adaptive_srrip_lru_bip_replacement_top - replacement policy testbench
// Drives find and update requests through the stream ports under several
// configurations, predicts victim way and set mode per request from a
// behavioral copy of the per-set RRIP, LRU, window and BIP state, and
// compares every result in order.
// ============================================================================
module tb_adaptive_srrip_lru_bip_replacement_top;

    localparam int N_SETS     = 2048;
    localparam int N_WAYS     = 16;
    localparam int IDLE_LIMIT = 10000;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 150;

    // Behavioral copy of the replacement state and the results it predicts
    class replacement_scoreboard;
        bit [arpl_pkg::RRIP_W-1:0] rrip_val   [N_SETS][N_WAYS];
        bit [3:0]                  lru_age    [N_SETS][N_WAYS];
        bit [arpl_pkg::CNT_W-1:0]  win_hits   [N_SETS];
        bit [arpl_pkg::CNT_W-1:0]  win_misses [N_SETS];
        bit [arpl_pkg::MODE_W-1:0] set_mode   [N_SETS];
        bit [arpl_pkg::BIP_W-1:0]  bip_misses;
        bit [arpl_pkg::CNT_W-1:0]  window_length;
        bit [arpl_pkg::CNT_W-1:0]  hit_threshold;
        bit [arpl_pkg::CNT_W-1:0]  miss_threshold;
        bit [arpl_pkg::BIP_W-1:0]  bip_period;
        arpl_pkg::res_t            expected_q[$];
        int                        errors;
        int                        lru_results;
        int                        bip_results;

        function new();
            for (int s = 0; s < N_SETS; s++) begin
                for (int w = 0; w < N_WAYS; w++) begin
                    rrip_val[s][w] = arpl_pkg::RRPV_DISTANT;
                    lru_age[s][w]  = 4'(w);
                end
                win_hits[s]   = '0;
                win_misses[s] = '0;
                set_mode[s]   = arpl_pkg::MODE_SRRIP;
            end
            bip_misses     = '0;
            window_length  = arpl_pkg::WINDOW_LENGTH_RST;
            hit_threshold  = arpl_pkg::HIT_THRESHOLD_RST;
            miss_threshold = arpl_pkg::MISS_THRESHOLD_RST;
            bip_period     = arpl_pkg::BIP_PERIOD_RST;
            errors         = 0;
            lru_results    = 0;
            bip_results    = 0;
        endfunction

        function void set_config(int wl, int ht, int mt, int bp);
            window_length  = arpl_pkg::CNT_W'(wl);
            hit_threshold  = arpl_pkg::CNT_W'(ht);
            miss_threshold = arpl_pkg::CNT_W'(mt);
            bip_period     = arpl_pkg::BIP_W'(bp);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Apply one accepted request to the state and queue its result
        function void note_request(arpl_pkg::req_t r);
            int unsigned               s;
            int unsigned               way;
            int unsigned               top;
            int unsigned               add;
            int unsigned               victim;
            bit [arpl_pkg::MODE_W-1:0] mode;
            bit [arpl_pkg::BIP_W-1:0]  next_count;
            bit [3:0]                  old_age;
            arpl_pkg::res_t            res;
            s      = r.set_index;
            way    = r.way_index;
            mode   = set_mode[s];
            victim = 0;
            if (r.req_type == arpl_pkg::REQ_FIND) begin
                top = 0;
                if (mode == arpl_pkg::MODE_LRU) begin
                    // oldest way, highest number wins a tie
                    for (int w = 0; w < N_WAYS; w++) begin
                        if (lru_age[s][w] >= top) begin
                            top    = lru_age[s][w];
                            victim = w;
                        end
                    end
                end else begin
                    // age the whole set until its maximum reaches distant
                    for (int w = 0; w < N_WAYS; w++)
                        if (rrip_val[s][w] > top) top = rrip_val[s][w];
                    add = arpl_pkg::RRPV_DISTANT - top;
                    for (int w = 0; w < N_WAYS; w++)
                        rrip_val[s][w] = arpl_pkg::RRIP_W'(rrip_val[s][w] + add);
                    for (int w = N_WAYS - 1; w >= 0; w--)
                        if (rrip_val[s][w] == arpl_pkg::RRPV_DISTANT) victim = w;
                end
            end else begin
                if (r.was_hit) begin
                    if (win_hits[s] != arpl_pkg::CNT_SAT) win_hits[s]++;
                end else begin
                    if (win_misses[s] != arpl_pkg::CNT_SAT) win_misses[s]++;
                end
                // end of window: pick the mode and restart the counts
                if (int'(win_hits[s]) + int'(win_misses[s]) >= int'(window_length)) begin
                    if (win_hits[s] > hit_threshold)
                        mode = arpl_pkg::MODE_LRU;
                    else if (win_misses[s] > miss_threshold)
                        mode = arpl_pkg::MODE_BIP;
                    else
                        mode = arpl_pkg::MODE_SRRIP;
                    set_mode[s]   = mode;
                    win_hits[s]   = '0;
                    win_misses[s] = '0;
                end
                if (mode == arpl_pkg::MODE_LRU) begin
                    old_age = lru_age[s][way];
                    for (int w = 0; w < N_WAYS; w++)
                        if (lru_age[s][w] < old_age) lru_age[s][w]++;
                    lru_age[s][way] = 0;
                end else if (mode == arpl_pkg::MODE_BIP) begin
                    if (r.was_hit) begin
                        rrip_val[s][way] = arpl_pkg::RRPV_NEAR;
                    end else begin
                        next_count = bip_misses + 1'b1;
                        if (next_count >= bip_period) begin
                            rrip_val[s][way] = arpl_pkg::RRPV_NEAR;
                            bip_misses       = '0;
                        end else begin
                            rrip_val[s][way] = arpl_pkg::RRPV_DISTANT;
                            bip_misses       = next_count;
                        end
                    end
                end else begin
                    rrip_val[s][way] = r.was_hit ? arpl_pkg::RRPV_NEAR : arpl_pkg::RRPV_LONG;
                end
            end
            res.victim_way = 4'(victim);
            res.set_mode   = mode;
            expected_q.push_back(res);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(logic [7:0] data);
            arpl_pkg::res_t exp_res;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: m_tdata %h", data);
                errors++;
            end else begin
                exp_res = expected_q.pop_front();
                if (data[3:0] !== exp_res.victim_way) begin
                    $error("victim_way mismatch: expected %0d, actual %0d",
                           exp_res.victim_way, data[3:0]);
                    errors++;
                end
                if (data[5:4] !== exp_res.set_mode) begin
                    $error("set_mode mismatch: expected %0d, actual %0d",
                           exp_res.set_mode, data[5:4]);
                    errors++;
                end
                if (exp_res.set_mode == arpl_pkg::MODE_LRU) lru_results++;
                if (exp_res.set_mode == arpl_pkg::MODE_BIP) bip_results++;
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn      = 1'b0;
    logic                           s_tvalid     = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata      = '0;
    logic [0:0]                     s_tuser      = '0;
    logic                           m_tvalid;
    logic                           m_tready     = 1'b0;
    logic [7:0]                     m_tdata;
    logic                           cfg_wr_en    = 1'b0;
    logic [arpl_pkg::CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [arpl_pkg::CFG_W-1:0]     cfg_wr_data  = '0;

    replacement_scoreboard board;
    bit                    no_idle;
    int                    requests_sent;
    int                    results_taken;
    int                    configs_run;
    int                    idle_cycles = 0;

    adaptive_srrip_lru_bip_replacement_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_gap();
        if (no_idle) return 0;
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 11);
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_req(input logic req, input logic [10:0] set_idx,
                            input logic [3:0] way, input logic hit);
        int             gap;
        arpl_pkg::req_t r;
        gap = draw_gap();
        r.req_type  = req;
        r.set_index = set_idx;
        r.way_index = way;
        r.was_hit   = hit;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hit, way, set_idx};
        s_tuser  <= req;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        board.note_request(r);
        requests_sent++;
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(input int wl, input int ht, input int mt, input int bp);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= arpl_pkg::CFG_WINDOW_LENGTH;
        cfg_wr_data  <= arpl_pkg::CFG_W'(wl);
        @(negedge aclk);
        cfg_wr_index <= arpl_pkg::CFG_HIT_THRESHOLD;
        cfg_wr_data  <= arpl_pkg::CFG_W'(ht);
        @(negedge aclk);
        cfg_wr_index <= arpl_pkg::CFG_MISS_THRESHOLD;
        cfg_wr_data  <= arpl_pkg::CFG_W'(mt);
        @(negedge aclk);
        cfg_wr_index <= arpl_pkg::CFG_BIP_PERIOD;
        cfg_wr_data  <= arpl_pkg::CFG_W'(bp);
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        board.set_config(wl, ht, mt, bp);
        configs_run++;
    endtask

    // One configuration: mostly hot sets, some full-set sweeps, some noise
    task automatic run_phase(input int wl, input int ht, input int mt, input int bp,
                             input int hit_pct, input int n_items, input bit full_rate);
        int unsigned hot_sets[4];
        int unsigned s;
        int unsigned off;
        int          sent;
        write_config(wl, ht, mt, bp);
        no_idle = full_rate;
        foreach (hot_sets[i]) hot_sets[i] = $urandom_range(0, N_SETS - 1);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 2) begin
                // touch every way of one set, then ask for a victim
                s   = hot_sets[$urandom_range(0, 3)];
                off = $urandom_range(0, N_WAYS - 1);
                for (int w = 0; w < N_WAYS; w++)
                    send_req(arpl_pkg::REQ_UPDATE, 11'(s), 4'((w + off) % N_WAYS),
                             $urandom_range(0, 99) < hit_pct);
                send_req(arpl_pkg::REQ_FIND, 11'(s), 4'($urandom), 1'($urandom));
                sent += N_WAYS + 1;
            end else begin
                s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, N_SETS - 1)
                                                : hot_sets[$urandom_range(0, 3)];
                send_req(($urandom_range(0, 99) < 35) ? arpl_pkg::REQ_FIND
                                                      : arpl_pkg::REQ_UPDATE,
                         11'(s), 4'($urandom_range(0, N_WAYS - 1)),
                         $urandom_range(0, 99) < hit_pct);
                sent++;
            end
        end
        drain();
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, one long hold-off to back up the block
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = (results_taken == HOLD_AT) ? HOLD_LEN : draw_gap();
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            board.check_result(m_tdata);
            results_taken++;
        end
    end

    // Watchdog on cycles without any accepted request or result
    always @(posedge aclk) begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
            (m_tvalid === 1'b1 && m_tready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("tb_adaptive_srrip_lru_bip_replacement_top: errors");
            $finish;
        end
    end

    initial begin
        board         = new();
        no_idle       = 1'b0;
        requests_sent = 0;
        results_taken = 0;
        configs_run   = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: set and way extremes, aging, repeated finds
        send_req(arpl_pkg::REQ_FIND,   11'd0,    4'd0,  1'b0);
        send_req(arpl_pkg::REQ_UPDATE, 11'd0,    4'd0,  1'b1);
        send_req(arpl_pkg::REQ_UPDATE, 11'd0,    4'd15, 1'b0);
        send_req(arpl_pkg::REQ_FIND,   11'd0,    4'd9,  1'b1);
        send_req(arpl_pkg::REQ_UPDATE, 11'd2047, 4'd15, 1'b1);
        send_req(arpl_pkg::REQ_UPDATE, 11'd2047, 4'd0,  1'b0);
        send_req(arpl_pkg::REQ_FIND,   11'd2047, 4'd15, 1'b0);
        send_req(arpl_pkg::REQ_FIND,   11'd2047, 4'd0,  1'b1);
        send_req(arpl_pkg::REQ_UPDATE, 11'd1365, 4'd5,  1'b1);
        send_req(arpl_pkg::REQ_UPDATE, 11'd682,  4'd10, 1'b0);
        send_req(arpl_pkg::REQ_FIND,   11'd1365, 4'd5,  1'b0);
        send_req(arpl_pkg::REQ_FIND,   11'd682,  4'd10, 1'b1);
        drain();

        // One-access windows: a hit switches to LRU, a miss to BIP
        write_config(1, 0, 0, 1);
        send_req(arpl_pkg::REQ_UPDATE, 11'd3, 4'd7,  1'b1);
        send_req(arpl_pkg::REQ_FIND,   11'd3, 4'd0,  1'b0);
        send_req(arpl_pkg::REQ_UPDATE, 11'd3, 4'd15, 1'b1);
        send_req(arpl_pkg::REQ_FIND,   11'd3, 4'd0,  1'b0);
        send_req(arpl_pkg::REQ_UPDATE, 11'd3, 4'd2,  1'b0);
        send_req(arpl_pkg::REQ_FIND,   11'd3, 4'd0,  1'b0);
        send_req(arpl_pkg::REQ_UPDATE, 11'd3, 4'd4,  1'b1);
        send_req(arpl_pkg::REQ_UPDATE, 11'd3, 4'd4,  1'b1);
        send_req(arpl_pkg::REQ_FIND,   11'd3, 4'd0,  1'b0);
        send_req(arpl_pkg::REQ_UPDATE, 11'd3, 4'd9,  1'b0);
        send_req(arpl_pkg::REQ_FIND,   11'd3, 4'd0,  1'b0);
        drain();

        run_phase(1,   0,   0,   1,  50, 110, 1'b0);
        run_phase(4,   2,   1,   3,  70, 110, 1'b0);
        run_phase(2,   1,   0,   7,  30, 110, 1'b1);
        run_phase(8,   5,   4,   31, 50, 110, 1'b0);
        run_phase(127, 127, 127, 31, 50, 100, 1'b0);
        run_phase(3,   0,   127, 2,  80, 100, 1'b0);
        repeat (2)
            run_phase($urandom_range(1, 12), $urandom_range(0, 8), $urandom_range(0, 8),
                      $urandom_range(1, 31), $urandom_range(10, 90), 110, 1'b0);

        $display("covered %0d requests under %0d register settings, %0d results checked",
                 requests_sent, configs_run + 1, results_taken);
        $display("results in LRU mode: %0d, in BIP mode: %0d",
                 board.lru_results, board.bip_results);
        if (board.errors == 0)
            $display("tb_adaptive_srrip_lru_bip_replacement_top: clean");
        else
            $display("tb_adaptive_srrip_lru_bip_replacement_top: errors");
        $finish;
    end

endmodule
